[hw/rtl/lz77_token_stream_decoder_macros.svh]
// assertion helpers used by the checker
`ifndef LZ77_TOKEN_STREAM_DECODER_MACROS_SVH
`define LZ77_TOKEN_STREAM_DECODER_MACROS_SVH

// same-cycle implication, sampled on the block clock
`define LZ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lz77 decoder check failed");

// next-cycle implication
`define LZ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lz77 decoder check failed");

`endif

[hw/rtl/lz77d_pkg.sv]
package lz77d_pkg;

   localparam int WINDOW_BYTES = 65536;
   localparam int COPY_BURST   = 64;

   localparam int ADDR_W  = $clog2(WINDOW_BYTES);
   localparam int BURST_W = $clog2(COPY_BURST + 1);

   localparam logic [1:0] STAT_RUN  = 2'd0;
   localparam logic [1:0] STAT_OK   = 2'd1;
   localparam logic [1:0] STAT_FAIL = 2'd2;

   localparam logic [3:0] NIBBLE_EXT = 4'hf;
   localparam logic [7:0] EXT_MORE   = 8'hff;
   localparam logic [3:0] MATCH_MIN  = 4'd4;

endpackage

[hw/rtl/lz77d_hist_ram.sv]
module lz77d_hist_ram
   import lz77d_pkg::*;
(
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [7:0]        wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [7:0]        rdata
);

   logic [7:0] mem [WINDOW_BYTES];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // a read of the entry being written returns the new byte
   always_ff @(posedge clock) begin
      if (re) begin
         if (we && (waddr == raddr)) begin
            rdata_ff <= wdata;
         end else begin
            rdata_ff <= mem[raddr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/lz77_token_stream_decoder.sv]
// LZ4-style block decoder, one compressed byte per request beat.
// req channel: opcode 0 offers a compressed byte, opcode 1 drains a pending
// match copy. rsp channel: one beat per decoded byte, or a single beat with
// byte_valid low for header, refused or ignored bytes; run_end marks the last
// beat of a request. csr_wr_en writes raw_size, the expected output length.
// Header bytes that start no copy, and literals: the response beat is registered
// in the cycle after the request beat, and a new request is taken every cycle
// while rsp is drained. Match copies: the first byte passes through ST_CPSET,
// the RAM read and ST_COPY, then one byte per cycle while rsp is drained, up
// to 64 per request; the rate is set by the read-then-write loop on the 64 KiB
// history RAM, whose write-to-read bypass covers an offset of one. No request
// is taken during a burst. A rsp stall holds the output register and freezes
// the copy engine; req_ready drops until the pending beat is taken. Synchronous
// reset returns the decoder to the start of a frame with raw_size 0. The history
// RAM is not cleared; only bytes of the current frame are ever read back.
module lz77_token_stream_decoder
   import lz77d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [7:0]  req_comp_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_byte_taken,
   output logic [1:0]  rsp_status,
   output logic        rsp_run_end,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CPSET = 2'd1;
   localparam logic [1:0] ST_COPY  = 2'd2;

   localparam logic [2:0] PH_TOKEN  = 3'd0;
   localparam logic [2:0] PH_LITEXT = 3'd1;
   localparam logic [2:0] PH_LIT    = 3'd2;
   localparam logic [2:0] PH_OFF0   = 3'd3;
   localparam logic [2:0] PH_OFF1   = 3'd4;
   localparam logic [2:0] PH_MEXT   = 3'd5;
   localparam logic [2:0] PH_DONE   = 3'd6;
   localparam logic [2:0] PH_FAIL   = 3'd7;

   logic [1:0]         state_ff, state_in;
   logic [2:0]         phase_ff, phase_in;
   logic [3:0]         match_code_ff, match_code_in;
   logic [31:0]        literals_left_ff, literals_left_in;
   logic [31:0]        match_length_ff, match_length_in;
   logic [15:0]        match_offset_ff, match_offset_in;
   logic [31:0]        bytes_out_ff, bytes_out_in;
   logic [31:0]        copy_left_ff, copy_left_in;
   logic               input_ended_ff, input_ended_in;
   logic [31:0]        raw_size_ff, raw_size_in;
   logic [BURST_W-1:0] burst_left_ff, burst_left_in;
   logic               q_valid_ff, q_valid_in;
   logic [1:0]         status_copy_ff, status_copy_in;
   logic               taken_ff, taken_in;
   logic               clear_end_ff, clear_end_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic               rsp_bvalid_ff, rsp_bvalid_in;
   logic               rsp_taken_ff, rsp_taken_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic               rsp_end_ff, rsp_end_in;

   logic               ram_we, ram_re;
   logic [ADDR_W-1:0]  ram_waddr, ram_raddr, rd_base;
   logic [7:0]         ram_wdata, ram_rdata;

   logic               slot_free, accept, taken, lit_out, copy_go, frame_clear, end_now, ok;
   logic [31:0]        room;
   logic               eq_now, eq_plus1;
   logic [32:0]        lit_sum, mat_sum;
   logic [31:0]        mlen;
   logic [15:0]        off_full;

   lz77d_hist_ram u_hist (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;

   assign room     = (bytes_out_ff >= raw_size_ff) ? 32'd0 : (raw_size_ff - bytes_out_ff);
   assign eq_now   = (bytes_out_ff == raw_size_ff);
   assign eq_plus1 = ((bytes_out_ff + 32'd1) == raw_size_ff);
   assign lit_sum  = {1'b0, literals_left_ff} + {25'd0, req_comp_byte};
   assign mat_sum  = {1'b0, match_length_ff} + {25'd0, req_comp_byte};
   assign mlen     = {28'd0, match_code_ff} + {28'd0, MATCH_MIN};
   assign off_full = {req_comp_byte, match_offset_ff[7:0]};
   assign rd_base  = bytes_out_ff[ADDR_W-1:0] - match_offset_ff[ADDR_W-1:0];

   always_comb begin
      state_in         = state_ff;
      phase_in         = phase_ff;
      match_code_in    = match_code_ff;
      literals_left_in = literals_left_ff;
      match_length_in  = match_length_ff;
      match_offset_in  = match_offset_ff;
      bytes_out_in     = bytes_out_ff;
      copy_left_in     = copy_left_ff;
      input_ended_in   = input_ended_ff;
      raw_size_in      = csr_wr_en ? csr_wr_data : raw_size_ff;
      burst_left_in    = burst_left_ff;
      q_valid_in       = q_valid_ff;
      status_copy_in   = status_copy_ff;
      taken_in         = taken_ff;
      clear_end_in     = clear_end_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_taken_in  = rsp_taken_ff;
      rsp_status_in = rsp_status_ff;
      rsp_end_in    = rsp_end_ff;

      ram_we      = 1'b0;
      ram_waddr   = bytes_out_ff[ADDR_W-1:0];
      ram_wdata   = req_comp_byte;
      ram_re      = 1'b0;
      ram_raddr   = rd_base;

      taken       = 1'b0;
      lit_out     = 1'b0;
      copy_go     = 1'b0;
      frame_clear = 1'b0;
      end_now     = 1'b0;
      ok          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_opcode && (copy_left_ff == 32'd0)) begin
                  taken = 1'b1;
                  unique case (phase_ff)
                     PH_TOKEN: begin
                        match_code_in = req_comp_byte[3:0];
                        if ({28'd0, req_comp_byte[7:4]} > room) begin
                           phase_in = PH_FAIL;
                        end else begin
                           literals_left_in = {28'd0, req_comp_byte[7:4]};
                           if (req_comp_byte[7:4] == NIBBLE_EXT) begin
                              phase_in = PH_LITEXT;
                           end else if (req_comp_byte[7:4] == 4'd0) begin
                              phase_in = eq_now ? PH_DONE : PH_OFF0;
                           end else begin
                              phase_in = PH_LIT;
                           end
                        end
                     end
                     PH_LITEXT: begin
                        if (lit_sum > {1'b0, room}) begin
                           phase_in = PH_FAIL;
                        end else begin
                           literals_left_in = lit_sum[31:0];
                           if (req_comp_byte != EXT_MORE) begin
                              if (lit_sum == 33'd0) begin
                                 phase_in = eq_now ? PH_DONE : PH_OFF0;
                              end else begin
                                 phase_in = PH_LIT;
                              end
                           end
                        end
                     end
                     PH_LIT: begin
                        lit_out          = 1'b1;
                        ram_we           = 1'b1;
                        bytes_out_in     = bytes_out_ff + 32'd1;
                        literals_left_in = literals_left_ff - 32'd1;
                        if (literals_left_ff == 32'd1) begin
                           phase_in = eq_plus1 ? PH_DONE : PH_OFF0;
                        end
                     end
                     PH_OFF0: begin
                        match_offset_in = {8'd0, req_comp_byte};
                        phase_in        = PH_OFF1;
                     end
                     PH_OFF1: begin
                        match_offset_in = off_full;
                        if ((off_full == 16'd0) || ({16'd0, off_full} > bytes_out_ff) ||
                            ({1'b0, off_full} > 17'(WINDOW_BYTES))) begin
                           phase_in = PH_FAIL;
                        end else begin
                           match_length_in = mlen;
                           if (mlen > room) begin
                              phase_in = PH_FAIL;
                           end else if (match_code_ff == NIBBLE_EXT) begin
                              phase_in = PH_MEXT;
                           end else begin
                              copy_left_in = mlen;
                              phase_in     = PH_TOKEN;
                           end
                        end
                     end
                     PH_MEXT: begin
                        if (mat_sum > {1'b0, room}) begin
                           phase_in = PH_FAIL;
                        end else begin
                           match_length_in = mat_sum[31:0];
                           if (req_comp_byte != EXT_MORE) begin
                              copy_left_in = mat_sum[31:0];
                              phase_in     = PH_TOKEN;
                           end
                        end
                     end
                     default: begin
                     end
                  endcase
                  if (req_last_byte) begin
                     input_ended_in = 1'b1;
                  end
               end
               copy_go  = req_opcode ? (copy_left_ff != 32'd0) :
                          (taken && (copy_left_in != 32'd0));
               taken_in = taken;
               if (copy_go) begin
                  state_in = ST_CPSET;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_byte_in   = lit_out ? req_comp_byte : 8'd0;
                  rsp_bvalid_in = lit_out;
                  rsp_taken_in  = taken;
                  rsp_end_in    = 1'b1;
                  rsp_status_in = (phase_in == PH_FAIL) ? STAT_FAIL : STAT_RUN;
                  if (input_ended_in && (copy_left_in == 32'd0)) begin
                     ok            = (phase_in == PH_DONE) || ((phase_in == PH_TOKEN) && eq_now);
                     rsp_status_in = ok ? STAT_OK : STAT_FAIL;
                     frame_clear   = 1'b1;
                  end
               end
            end
         end
         ST_CPSET: begin
            ram_re        = 1'b1;
            q_valid_in    = 1'b1;
            burst_left_in = (copy_left_ff <= 32'(COPY_BURST)) ?
                            copy_left_ff[BURST_W-1:0] : BURST_W'(COPY_BURST);
            end_now       = input_ended_ff && (copy_left_ff <= 32'(COPY_BURST));
            ok            = ((bytes_out_ff + copy_left_ff) == raw_size_ff);
            status_copy_in = end_now ? (ok ? STAT_OK : STAT_FAIL) : STAT_RUN;
            clear_end_in  = end_now;
            state_in      = ST_COPY;
         end
         ST_COPY: begin
            if (q_valid_ff && slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = ram_rdata;
               rsp_bvalid_in = 1'b1;
               rsp_taken_in  = taken_ff;
               rsp_status_in = status_copy_ff;
               rsp_end_in    = (burst_left_ff == BURST_W'(1));
               ram_we        = 1'b1;
               ram_wdata     = ram_rdata;
               bytes_out_in  = bytes_out_ff + 32'd1;
               copy_left_in  = copy_left_ff - 32'd1;
               burst_left_in = burst_left_ff - BURST_W'(1);
               if (burst_left_ff != BURST_W'(1)) begin
                  ram_re    = 1'b1;
                  ram_raddr = rd_base + ADDR_W'(1);
               end else begin
                  q_valid_in  = 1'b0;
                  state_in    = ST_IDLE;
                  frame_clear = clear_end_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (frame_clear) begin
         phase_in         = PH_TOKEN;
         match_code_in    = 4'd0;
         literals_left_in = 32'd0;
         match_length_in  = 32'd0;
         match_offset_in  = 16'd0;
         bytes_out_in     = 32'd0;
         copy_left_in     = 32'd0;
         input_ended_in   = 1'b0;
         clear_end_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         phase_ff         <= PH_TOKEN;
         match_code_ff    <= 4'd0;
         literals_left_ff <= 32'd0;
         match_length_ff  <= 32'd0;
         match_offset_ff  <= 16'd0;
         bytes_out_ff     <= 32'd0;
         copy_left_ff     <= 32'd0;
         input_ended_ff   <= 1'b0;
         raw_size_ff      <= 32'd0;
         q_valid_ff       <= 1'b0;
         clear_end_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         phase_ff         <= phase_in;
         match_code_ff    <= match_code_in;
         literals_left_ff <= literals_left_in;
         match_length_ff  <= match_length_in;
         match_offset_ff  <= match_offset_in;
         bytes_out_ff     <= bytes_out_in;
         copy_left_ff     <= copy_left_in;
         input_ended_ff   <= input_ended_in;
         raw_size_ff      <= raw_size_in;
         q_valid_ff       <= q_valid_in;
         clear_end_ff     <= clear_end_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      burst_left_ff  <= burst_left_in;
      status_copy_ff <= status_copy_in;
      taken_ff       <= taken_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_bvalid_ff  <= rsp_bvalid_in;
      rsp_taken_ff   <= rsp_taken_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_end_ff     <= rsp_end_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_byte_valid = rsp_bvalid_ff;
   assign rsp_byte_taken = rsp_taken_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_run_end    = rsp_end_ff;

endmodule

[hw/rtl/lz77d_checker.sv]
`include "lz77_token_stream_decoder_macros.svh"

module lz77d_checker
   import lz77d_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_byte_valid,
   input logic [1:0]  rsp_status,
   input logic        rsp_run_end
);

   // a beat without a byte is always the only beat of its request
   `LZ_ASSERT_NOW(a_empty_ends, rsp_valid && !rsp_byte_valid, rsp_run_end && !(|rsp_out_byte))

   // no new request while a copy burst is still in flight
   `LZ_ASSERT_NOW(a_no_req_mid_burst, rsp_valid && rsp_byte_valid && !rsp_run_end, !req_ready)

   // status carries only defined codes
   `LZ_ASSERT_NOW(a_status_code, rsp_valid, rsp_status <= STAT_FAIL)

   // stalled response beat holds
   `LZ_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_out_byte, rsp_status}))

endmodule

bind lz77_token_stream_decoder lz77d_checker u_lz77d_checker (.*);

[test/tb_top.sv]
module tb_top;
   import lz77d_pkg::*;

   localparam bit OP_DATA  = 1'b0;
   localparam bit OP_DRAIN = 1'b1;
   localparam int RANDOM_ITEMS = 36;

   typedef enum logic [3:0] {
      DEC_TOKEN, DEC_LIT_EXT, DEC_LITERAL, DEC_OFFSET_LO, DEC_OFFSET_HI,
      DEC_MATCH_EXT, DEC_DONE, DEC_FAILED
   } dec_phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       byte_taken;
      logic [1:0] status;
      logic       run_end;
   } dec_result_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_opcode = 1'b0;
   logic [7:0]  req_comp_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_byte_taken;
   logic [1:0]  rsp_status;
   logic        rsp_run_end;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = 32'h0;

   lz77_token_stream_decoder uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_comp_byte  (req_comp_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_byte_taken (rsp_byte_taken),
      .rsp_status     (rsp_status),
      .rsp_run_end    (rsp_run_end),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   initial begin
      #16000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // decoder state as the testbench sees it
   logic [31:0]   model_raw_size = 32'h0;
   dec_phase_type dec_phase = DEC_TOKEN;
   logic [3:0]    match_code_m = 4'h0;
   logic [31:0]   lit_left_m = 32'h0;
   logic [31:0]   match_len_m = 32'h0;
   logic [15:0]   offset_m = 16'h0;
   logic [31:0]   bytes_out_m = 32'h0;
   logic [31:0]   copy_left_m = 32'h0;
   bit            input_ended_m = 1'b0;
   logic [7:0]    history_m [WINDOW_BYTES];
   logic [7:0]    burst_q [$];

   dec_result_type expected_beats [$];
   logic [7:0]     frame_bytes [$];
   int             plan_bytes;

   int fail_count = 0;
   int beats_checked = 0;
   int useful_items = 0;
   int refused_items = 0;
   int copied_bytes = 0;
   int frames_ok = 0;
   int frames_failed = 0;
   int raw_writes = 0;
   int refuse_pct = 15;
   int rx_hold_cycles = 0;
   bit no_gaps = 1'b0;

   function automatic int pick_gap();
      int r;
      if (no_gaps)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 94)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void clear_frame_state();
      dec_phase = DEC_TOKEN;
      match_code_m = 4'h0;
      lit_left_m = 32'h0;
      match_len_m = 32'h0;
      offset_m = 16'h0;
      bytes_out_m = 32'h0;
      copy_left_m = 32'h0;
      input_ended_m = 1'b0;
   endfunction

   function automatic logic [63:0] room_left();
      if (bytes_out_m >= model_raw_size)
         return 64'd0;
      return 64'(model_raw_size - bytes_out_m);
   endfunction

   function automatic void emit_byte(logic [7:0] b);
      history_m[bytes_out_m % WINDOW_BYTES] = b;
      bytes_out_m++;
      burst_q = {burst_q, b};
   endfunction

   function automatic void end_literals();
      dec_phase = (bytes_out_m == model_raw_size) ? DEC_DONE : DEC_OFFSET_LO;
   endfunction

   function automatic void take_literal_count(logic [63:0] n);
      if (n > room_left())
         dec_phase = DEC_FAILED;
      else
         lit_left_m = n[31:0];
   endfunction

   function automatic void decode_data(logic [7:0] b);
      logic [63:0] sum;
      case (dec_phase)
         DEC_TOKEN: begin
            match_code_m = b[3:0];
            take_literal_count(64'(b[7:4]));
            if (dec_phase != DEC_FAILED) begin
               if (b[7:4] == NIBBLE_EXT)
                  dec_phase = DEC_LIT_EXT;
               else if (lit_left_m == 0)
                  end_literals();
               else
                  dec_phase = DEC_LITERAL;
            end
         end
         DEC_LIT_EXT: begin
            take_literal_count(64'(lit_left_m) + 64'(b));
            if (dec_phase != DEC_FAILED && b != EXT_MORE) begin
               if (lit_left_m == 0)
                  end_literals();
               else
                  dec_phase = DEC_LITERAL;
            end
         end
         DEC_LITERAL: begin
            emit_byte(b);
            lit_left_m--;
            if (lit_left_m == 0)
               end_literals();
         end
         DEC_OFFSET_LO: begin
            offset_m = {8'h00, b};
            dec_phase = DEC_OFFSET_HI;
         end
         DEC_OFFSET_HI: begin
            offset_m[15:8] = b;
            if (offset_m == 0 || offset_m > bytes_out_m || offset_m > WINDOW_BYTES) begin
               dec_phase = DEC_FAILED;
            end else begin
               match_len_m = 32'(match_code_m) + 32'(MATCH_MIN);
               if (64'(match_len_m) > room_left()) begin
                  dec_phase = DEC_FAILED;
               end else if (match_code_m == NIBBLE_EXT) begin
                  dec_phase = DEC_MATCH_EXT;
               end else begin
                  copy_left_m = match_len_m;
                  dec_phase = DEC_TOKEN;
               end
            end
         end
         DEC_MATCH_EXT: begin
            sum = 64'(match_len_m) + 64'(b);
            if (sum > room_left()) begin
               dec_phase = DEC_FAILED;
            end else begin
               match_len_m = sum[31:0];
               if (b != EXT_MORE) begin
                  copy_left_m = match_len_m;
                  dec_phase = DEC_TOKEN;
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void copy_match_burst();
      int k;
      logic [31:0] src;
      k = 0;
      while (copy_left_m != 0 && k < COPY_BURST) begin
         src = bytes_out_m - 32'(offset_m);
         emit_byte(history_m[src % WINDOW_BYTES]);
         copy_left_m--;
         copied_bytes++;
         k++;
      end
   endfunction

   function automatic void predict_beat(bit op, logic [7:0] b, bit last_flag);
      dec_result_type beat;
      bit taken;
      logic [1:0] st;
      int nres;
      burst_q.delete();
      taken = 1'b0;
      if (op == OP_DATA) begin
         if (copy_left_m == 0) begin
            taken = 1'b1;
            decode_data(b);
            if (copy_left_m != 0)
               copy_match_burst();
            if (last_flag)
               input_ended_m = 1'b1;
         end else begin
            refused_items++;
         end
      end else if (copy_left_m != 0) begin
         copy_match_burst();
      end
      if (taken || burst_q.size() > 0)
         useful_items++;
      st = (dec_phase == DEC_FAILED) ? STAT_FAIL : STAT_RUN;
      if (input_ended_m && copy_left_m == 0) begin
         if (dec_phase == DEC_DONE ||
             (dec_phase == DEC_TOKEN && bytes_out_m == model_raw_size)) begin
            st = STAT_OK;
            frames_ok++;
         end else begin
            st = STAT_FAIL;
            frames_failed++;
         end
         clear_frame_state();
      end
      nres = (burst_q.size() > 0) ? burst_q.size() : 1;
      for (int k = 0; k < nres; k++) begin
         beat.out_byte   = (burst_q.size() > 0) ? burst_q[k] : 8'h00;
         beat.byte_valid = (burst_q.size() > 0);
         beat.byte_taken = taken;
         beat.status     = st;
         beat.run_end    = (k == nres - 1);
         expected_beats = {expected_beats, beat};
      end
   endfunction

   always @(posedge clock) begin
      dec_result_type got;
      dec_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.out_byte   = rsp_out_byte;
         got.byte_valid = rsp_byte_valid;
         got.byte_taken = rsp_byte_taken;
         got.status     = rsp_status;
         got.run_end    = rsp_run_end;
         beats_checked++;
         if (expected_beats.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("rsp beat %0d arrived with nothing pending: byte %02h valid %0b",
                        beats_checked, got.out_byte, got.byte_valid);
         end else begin
            want = expected_beats.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                got.byte_taken !== want.byte_taken || got.status !== want.status ||
                got.run_end !== want.run_end) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $write("rsp beat %0d: expected byte %02h valid %0b taken %0b status %0d",
                         beats_checked, want.out_byte, want.byte_valid, want.byte_taken,
                         want.status);
                  $display(" end %0b, got byte %02h valid %0b taken %0b status %0d end %0b",
                           want.run_end, got.out_byte, got.byte_valid, got.byte_taken,
                           got.status, got.run_end);
               end
            end
         end
      end
   end

   // receiver side: random stalls plus a long hold-off on request
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (rx_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            rx_hold_cycles--;
         end else if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   task automatic send_beat(input bit op, input logic [7:0] b, input bit last_flag);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_comp_byte <= b;
      req_last_byte <= last_flag;
      do
         @(posedge clock);
      while (req_ready !== 1'b1);
      predict_beat(op, b, last_flag);
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_beats.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_raw_size(input logic [31:0] v);
      wait_quiet();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      model_raw_size = v;
      raw_writes++;
   endtask

   task automatic drain_copy();
      while (copy_left_m != 0) begin
         if ($urandom_range(0, 99) < refuse_pct)
            send_beat(OP_DATA, 8'($urandom), 1'($urandom));
         send_beat(OP_DRAIN, 8'($urandom), 1'($urandom));
      end
   endtask

   task automatic play_frame(input logic [31:0] raw);
      write_raw_size(raw);
      foreach (frame_bytes[i]) begin
         drain_copy();
         send_beat(OP_DATA, frame_bytes[i], i == frame_bytes.size() - 1);
      end
      drain_copy();
   endtask

   task automatic close_frame();
      if (dec_phase != DEC_TOKEN || bytes_out_m != 0 || copy_left_m != 0 || input_ended_m) begin
         drain_copy();
         send_beat(OP_DATA, 8'($urandom), 1'b1);
         drain_copy();
      end
   endtask

   function automatic logic [7:0] pick_literal();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void append_frame_byte(logic [7:0] b);
      frame_bytes = {frame_bytes, b};
   endfunction

   function automatic void add_sequence(int lits, int mlen, bit with_match);
      int code;
      int rest;
      int off;
      int lim;
      code = 0;
      if (with_match)
         code = (mlen - int'(MATCH_MIN) >= int'(NIBBLE_EXT)) ? int'(NIBBLE_EXT)
                                                            : mlen - int'(MATCH_MIN);
      append_frame_byte({4'((lits >= int'(NIBBLE_EXT)) ? int'(NIBBLE_EXT) : lits),
                         4'(code)});
      if (lits >= int'(NIBBLE_EXT)) begin
         rest = lits - int'(NIBBLE_EXT);
         while (rest >= int'(EXT_MORE)) begin
            append_frame_byte(EXT_MORE);
            rest -= int'(EXT_MORE);
         end
         append_frame_byte(8'(rest));
      end
      repeat (lits) append_frame_byte(pick_literal());
      plan_bytes += lits;
      if (with_match) begin
         if ($urandom_range(0, 99) < 60)
            lim = 4;
         else if ($urandom_range(0, 9) < 8)
            lim = 64;
         else
            lim = plan_bytes;
         if (lim > plan_bytes)
            lim = plan_bytes;
         off = $urandom_range(1, lim);
         append_frame_byte(off[7:0]);
         append_frame_byte(off[15:8]);
         if (code == int'(NIBBLE_EXT)) begin
            rest = mlen - int'(NIBBLE_EXT) - int'(MATCH_MIN);
            while (rest >= int'(EXT_MORE)) begin
               append_frame_byte(EXT_MORE);
               rest -= int'(EXT_MORE);
            end
            append_frame_byte(8'(rest));
         end
         plan_bytes += mlen;
      end
   endfunction

   function automatic void build_random_frame();
      int nseq;
      int lits;
      int mlen;
      bit with_match;
      frame_bytes.delete();
      plan_bytes = 0;
      nseq = $urandom_range(1, 3);
      for (int s = 0; s < nseq; s++) begin
         lits = ($urandom_range(0, 99) < 8) ? $urandom_range(15, 30) : $urandom_range(0, 4);
         if (plan_bytes + lits == 0)
            lits = 1;
         with_match = (s < nseq - 1) || ($urandom_range(0, 1) == 1);
         mlen = ($urandom_range(0, 99) < 10) ? $urandom_range(19, 300) : $urandom_range(4, 18);
         add_sequence(lits, mlen, with_match);
      end
   endfunction

   function automatic logic [31:0] pick_raw_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75)
         return 32'(plan_bytes);
      if (r < 85)
         return 32'(plan_bytes + $urandom_range(1, 3));
      if (r < 95)
         return 32'(plan_bytes - $urandom_range(1, plan_bytes));
      return $urandom();
   endfunction

   // truncate the frame or corrupt one byte of it
   function automatic void break_frame();
      int cut;
      if ($urandom_range(0, 1) == 0) begin
         cut = $urandom_range(1, frame_bytes.size());
         while (frame_bytes.size() > cut)
            void'(frame_bytes.pop_back());
      end else begin
         frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom);
      end
   endfunction

   task automatic noise_frame();
      int count;
      write_raw_size($urandom_range(0, 64));
      count = $urandom_range(8, 20);
      repeat (count) begin
         if ($urandom_range(0, 9) == 0)
            send_beat(OP_DRAIN, 8'($urandom), 1'($urandom));
         else
            send_beat(OP_DATA, 8'($urandom), $urandom_range(0, 9) == 0);
      end
      close_frame();
   endtask

   task automatic test_zero_size();
      // token with no literals completes an empty frame, later bytes ignored
      frame_bytes = '{8'h00, 8'hAB};
      play_frame(32'h0);
      // continue with no copy pending
      send_beat(OP_DRAIN, 8'hFF, 1'b1);
   endtask

   task automatic test_long_overlap_match();
      // offset one, match length through a 255 extension, ending on the header
      refuse_pct = 100;
      frame_bytes = '{8'h1F, 8'hA5, 8'h01, 8'h00, 8'hFF, 8'h00};
      play_frame(32'd275);
      refuse_pct = 15;
   endtask

   task automatic test_frame_errors();
      frame_bytes = '{8'h10};
      play_frame(32'h0);
      frame_bytes = '{8'h20, 8'h41};
      play_frame(32'd5);
      frame_bytes = '{8'hF0, 8'hFF};
      play_frame(32'hFFFF_FFFF);
      frame_bytes = '{8'h10, 8'h7F, 8'h00, 8'h00};
      play_frame(32'd10);
      frame_bytes = '{8'h10, 8'h7F, 8'h02, 8'h00};
      play_frame(32'd10);
      frame_bytes = '{8'h10, 8'h7F, 8'h01};
      play_frame(32'd10);
      frame_bytes = '{8'h10, 8'h55, 8'h01, 8'h00, 8'h3C};
      play_frame(32'd4);
   endtask

   task automatic test_output_backpressure();
      frame_bytes.delete();
      plan_bytes = 0;
      add_sequence(20, 40, 1'b1);
      add_sequence(6, 0, 1'b0);
      no_gaps = 1'b1;
      write_raw_size(32'(plan_bytes));
      // receiver holds off while the sender keeps offering beats
      rx_hold_cycles = 200;
      foreach (frame_bytes[i]) begin
         drain_copy();
         send_beat(OP_DATA, frame_bytes[i], i == frame_bytes.size() - 1);
      end
      drain_copy();
      no_gaps = 1'b0;
   endtask

   task automatic test_random_frames();
      int start;
      int kind;
      start = useful_items;
      while (useful_items - start < RANDOM_ITEMS) begin
         no_gaps = ($urandom_range(0, 4) == 0);
         kind = $urandom_range(0, 99);
         if (kind < 13) begin
            noise_frame();
         end else begin
            build_random_frame();
            if (kind < 25)
               break_frame();
            play_frame(pick_raw_size());
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_zero_size();
      test_long_overlap_match();
      test_frame_errors();
      test_output_backpressure();
      test_random_frames();
      wait_quiet();
      repeat (40) @(posedge clock);
      $display("run: %0d request beats decoded, %0d refused, %0d rsp beats, %0d copied bytes",
               useful_items, refused_items, beats_checked, copied_bytes);
      $display("frames: %0d finished ok, %0d failed, %0d raw_size writes",
               frames_ok, frames_failed, raw_writes);
      if (fail_count == 0 && expected_beats.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
